@@ src/rdl_pkg.sv @@
// Shared constants, codes and types of the resource directory lookup.
package rdl_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int ID_W        = 16;
   localparam int WORD_W      = 32;
   localparam int ENTRY_W     = ID_W + WORD_W;
   localparam int TYPE_W      = 5;
   localparam int OFF_W       = 28;
   localparam int VOL_W       = 6;
   localparam int TYPE_SHIFT  = 11;
   localparam int NARROW_OFF_W = 26;
   localparam int WIDE_VOL_W  = 4;

   localparam logic [ID_W-1:0] END_ID = '1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] offset;
      logic [VOL_W-1:0] vol_num;
   } result_type;

endpackage

@@ src/rdl_req_if.sv @@
// Request channel: load or query item with valid/ready handshake.
interface rdl_req_if;
   import rdl_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic              first_entry;
   logic [ID_W-1:0]   entry_id;
   logic [WORD_W-1:0] entry_word;
   logic [TYPE_W-1:0] res_type;
   logic [ID_W-1:0]   res_num;
   logic [VOL_W-1:0]  want_vol;

   modport source (
      output valid, op, first_entry, entry_id, entry_word, res_type, res_num, want_vol,
      input  ready
   );
   modport sink (
      input  valid, op, first_entry, entry_id, entry_word, res_type, res_num, want_vol,
      output ready
   );
endinterface

@@ src/rdl_rsp_if.sv @@
// Response channel: query result item with valid/ready handshake.
interface rdl_rsp_if;
   import rdl_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [OFF_W-1:0] offset;
   logic [VOL_W-1:0] vol_num;

   modport source (
      output valid, found, offset, vol_num,
      input  ready
   );
   modport sink (
      input  valid, found, offset, vol_num,
      output ready
   );
endinterface

@@ src/rdl_table.sv @@
// Directory memory: one write port, one registered read port.
module rdl_table (
   input  logic                       clock,
   input  rdl_pkg::mem_req_type       mem_req,
   output logic [rdl_pkg::ENTRY_W-1:0] rd_data
);
   import rdl_pkg::*;

   logic [ENTRY_W-1:0] dir_mem_ff [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         dir_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= dir_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rdl_scan.sv @@
// Load sequencing and query scan over the directory memory.
module rdl_scan (
   input  logic                        clock,
   input  logic                        reset,
   rdl_req_if.sink                     req_ch,
   input  logic                        slot_free,
   input  logic [rdl_pkg::ENTRY_W-1:0] rd_data,
   output rdl_pkg::mem_req_type        mem_req,
   output logic                        res_valid,
   output rdl_pkg::result_type         res
);
   import rdl_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              wide_ff, wide_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [VOL_W-1:0]  want_ff, want_in;
   result_type        res_ff, res_in;

   logic              accept;
   logic [ADDR_W-1:0] load_addr;
   logic              load_ok;
   logic [ID_W-1:0]   ent_id;
   logic [WORD_W-1:0] ent_word;
   logic [OFF_W-1:0]  ent_off;
   logic [VOL_W-1:0]  ent_vol;
   logic              end_hit;
   logic              match;
   logic              stop;
   logic              issue;
   logic              done;

   assign accept  = req_ch.valid && req_ch.ready;
   assign ent_id   = rd_data[ENTRY_W-1 -: ID_W];
   assign ent_word = rd_data[WORD_W-1:0];

   // Layout is chosen by the top nibble of entry zero.
   always_comb begin
      if (wide_ff) begin
         ent_off = ent_word[OFF_W-1:0];
         ent_vol = VOL_W'(ent_word[WORD_W-1 -: WIDE_VOL_W]);
      end else begin
         ent_off = OFF_W'(ent_word[NARROW_OFF_W-1:0]);
         ent_vol = ent_word[WORD_W-1 -: VOL_W];
      end
   end

   assign end_hit = pend_ff && (ent_id == END_ID);
   assign match   = pend_ff && !end_hit && (ent_id == id_ff);
   assign stop    = end_hit || (match && (ent_vol == want_ff));
   assign issue   = (issue_ff < count_ff);
   assign done    = stop || (!pend_ff && !issue);

   assign load_addr = req_ch.first_entry ? '0 : count_ff[ADDR_W-1:0];
   assign load_ok   = req_ch.first_entry || (count_ff < CNT_W'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         wide_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wide_ff  <= wide_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      id_ff    <= id_in;
      want_ff  <= want_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      wide_in  = wide_ff;
      issue_in = issue_ff;
      pend_in  = 1'b0;
      id_in    = id_ff;
      want_in  = want_ff;
      res_in   = res_ff;
      mem_req  = '0;
      req_ch.ready = 1'b0;
      res_valid    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Loads only land here, so writes never overlap a scan.
            req_ch.ready = 1'b1;
            if (accept && req_ch.op == OP_LOAD && load_ok) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = load_addr;
               mem_req.wr_data = {req_ch.entry_id, req_ch.entry_word};
               count_in = CNT_W'(load_addr) + 1'b1;
               if (load_addr == '0) begin
                  wide_in = (req_ch.entry_word[WORD_W-1 -: WIDE_VOL_W] != '0);
               end
            end else if (accept && req_ch.op == OP_QUERY) begin
               id_in   = req_ch.res_num | (ID_W'(req_ch.res_type) << TYPE_SHIFT);
               want_in = req_ch.want_vol;
               issue_in = '0;
               res_in.found   = 1'b0;
               res_in.offset  = '0;
               res_in.vol_num = req_ch.want_vol;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               res_in.found   = 1'b1;
               res_in.offset  = ent_off;
               res_in.vol_num = ent_vol;
            end
            if (done) begin
               state_in = ST_DONE;
            end else if (issue) begin
               // Read one entry a cycle; data is checked the next cycle.
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = issue_ff[ADDR_W-1:0];
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

@@ src/resource_directory_lookup.sv @@
// Resource directory lookup block.
//
// req_ch carries load and query items (valid/ready). A load writes one entry
// at the fill count, or at entry zero when first_entry is set; loads past the
// table depth are dropped. A query scans the directory one entry per cycle
// through the single read port of the directory memory, stopping at the fill
// count, at an end-of-list id or at a match on the wanted volume. A load
// produces no result.
// rsp_ch carries one item per query from an output register. While a result
// waits there, the block still accepts loads and the next query; a finished
// scan holds until the output register frees up.
// Reset (synchronous, active high) empties the directory: fill count and
// layout flag clear; memory contents need no clearing pass.
module resource_directory_lookup (
   input  logic      clock,
   input  logic      reset,
   rdl_req_if.sink   req_ch,
   rdl_rsp_if.source rsp_ch
);
   import rdl_pkg::*;

   mem_req_type        mem_req;
   logic [ENTRY_W-1:0] rd_data;
   logic               res_valid;
   result_type         res;
   logic               slot_free;
   logic               rsp_valid_ff;
   result_type         rsp_data_ff;

   rdl_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rdl_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .mem_req   (mem_req),
      .res_valid (res_valid),
      .res       (res)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.found   = rsp_data_ff.found;
   assign rsp_ch.offset  = rsp_data_ff.offset;
   assign rsp_ch.vol_num = rsp_data_ff.vol_num;

endmodule

@@ verif/resource_directory_lookup_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the resource directory lookup: directed and random loads and queries.
module resource_directory_lookup_test;
   import rdl_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int TAIL_CYCLES  = 16;
   localparam int RANDOM_ITEMS = 115;

   logic clock;
   logic reset;

   rdl_req_if req_ch();
   rdl_rsp_if rsp_ch();

   resource_directory_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the directory
   logic [ID_W-1:0]   dir_ids   [TABLE_DEPTH];
   logic [WORD_W-1:0] dir_words [TABLE_DEPTH];
   int                dir_fill = 0;
   bit                dir_wide = 1'b0;

   result_type pending_lookups[$];
   int         error_count = 0;
   int         burst_left = 0;
   bit         no_idle = 1'b0;
   int         rx_run_left = 0;
   bit         rx_stalling = 1'b0;
   int         idle_cycles = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void split_word(input logic [WORD_W-1:0] word,
                                      output logic [OFF_W-1:0] off,
                                      output logic [VOL_W-1:0] vol);
      if (dir_wide) begin
         off = word[OFF_W-1:0];
         vol = VOL_W'(word[WORD_W-1:OFF_W]);
      end else begin
         off = OFF_W'(word[NARROW_OFF_W-1:0]);
         vol = word[WORD_W-1:NARROW_OFF_W];
      end
   endfunction

   function automatic result_type lookup_directory(logic [TYPE_W-1:0] rtype,
                                                   logic [ID_W-1:0] num,
                                                   logic [VOL_W-1:0] want);
      logic [ID_W-1:0]  qid;
      logic [OFF_W-1:0] off;
      logic [VOL_W-1:0] vol;
      result_type       res;
      qid = num | (ID_W'(rtype) << TYPE_SHIFT);
      res.found = 1'b0;
      res.offset = '0;
      res.vol_num = want;
      for (int i = 0; i < dir_fill; i++) begin
         if (dir_ids[i] == END_ID)
            break;
         if (dir_ids[i] == qid) begin
            split_word(dir_words[i], off, vol);
            res.found = 1'b1;
            res.offset = off;
            res.vol_num = vol;
            if (vol == want)
               break;
         end
      end
      return res;
   endfunction

   // Call at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(logic op, logic first, logic [ID_W-1:0] id,
                            logic [WORD_W-1:0] word, logic [TYPE_W-1:0] rtype,
                            logic [ID_W-1:0] num, logic [VOL_W-1:0] want);
      int gap;
      if (burst_left == 0) begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.first_entry <= first;
      req_ch.entry_id    <= id;
      req_ch.entry_word  <= word;
      req_ch.res_type    <= rtype;
      req_ch.res_num     <= num;
      req_ch.want_vol    <= want;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_LOAD) begin
         if (first)
            dir_fill = 0;
         if (dir_fill < TABLE_DEPTH) begin
            dir_ids[dir_fill] = id;
            dir_words[dir_fill] = word;
            if (dir_fill == 0)
               dir_wide = (word[WORD_W-1:OFF_W] != '0);
            dir_fill++;
         end
      end else begin
         pending_lookups.push_back(lookup_directory(rtype, num, want));
      end
   endtask

   // Query fields are don't-care on a load; randomize them.
   task automatic send_load(logic first, logic [ID_W-1:0] id, logic [WORD_W-1:0] word);
      send_item(OP_LOAD, first, id, word, TYPE_W'($urandom), ID_W'($urandom),
                VOL_W'($urandom));
   endtask

   // Load fields are don't-care on a query; randomize them.
   task automatic send_query(logic [TYPE_W-1:0] rtype, logic [ID_W-1:0] num,
                             logic [VOL_W-1:0] want);
      send_item(OP_QUERY, 1'($urandom), ID_W'($urandom), $urandom, rtype, num, want);
   endtask

   task automatic test_empty_directory();
      send_query('1, '1, '1);
      send_query('0, '0, '0);
   endtask

   task automatic test_narrow_layout();
      // entry zero has a clear top nibble, so the 26-bit offset layout holds
      send_load(1'b1, 16'h0000, {6'd3, 26'h3FF_FFFF});
      send_load(1'b0, 16'hA5C3, {6'd63, 26'h000_0000});
      send_load(1'b0, 16'hA5C3, {6'd0, 26'h155_5555});
      send_load(1'b0, 16'hA5C3, {6'd63, 26'h2AA_AAAA});
      send_load(1'b0, END_ID, '0);
      send_load(1'b0, 16'h1234, {6'd7, 26'h000_0001});
      send_query(5'd0, 16'h0000, 6'd3);
      send_query(5'h14, 16'h05C3, 6'd63);
      send_query(5'd0, 16'hA5C3, 6'd0);
      send_query(5'h14, 16'hA5C3, 6'd5);
      // hidden behind the end-of-list marker
      send_query(5'd0, 16'h1234, 6'd7);
      send_query(5'h1F, 16'hFFFF, 6'd0);
      send_query(5'h1F, 16'h07FF, 6'd33);
   endtask

   task automatic test_wide_layout();
      send_load(1'b1, 16'h0001, '1);
      send_load(1'b0, 16'h0001, '0);
      send_query(5'd0, 16'h0001, 6'd15);
      send_query(5'd0, 16'h0001, 6'd0);
      send_query(5'd0, 16'h0001, 6'd40);
      send_query(5'd0, 16'h0001, 6'd63);
   endtask

   task automatic test_random_sessions();
      logic [ID_W-1:0]   pool [4];
      logic [ID_W-1:0]   id;
      logic [ID_W-1:0]   mask;
      logic [WORD_W-1:0] word;
      logic [TYPE_W-1:0] rtype;
      logic [ID_W-1:0]   num;
      logic [VOL_W-1:0]  want;
      logic [OFF_W-1:0]  off;
      logic              first;
      int                sent;
      int                n_loads;
      int                n_queries;
      int                span;
      int                mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         foreach (pool[k])
            pool[k] = ID_W'($urandom);
         n_loads = $urandom_range(1, 14);
         for (int j = 0; j < n_loads; j++) begin
            id = pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 15) == 0)
               id = END_ID;
            else if ($urandom_range(0, 7) == 0)
               id = ID_W'($urandom);
            word = $urandom;
            if (j == 0 && $urandom_range(0, 1))
               word[WORD_W-1:OFF_W] = '0;
            // mostly a clean restart, now and then an append or a stray restart
            first = (j == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
            send_load(first, id, word);
            sent++;
         end
         n_queries = $urandom_range(1, 6);
         for (int j = 0; j < n_queries; j++) begin
            span = (dir_fill > 64) ? 64 : dir_fill;
            mode = $urandom_range(0, 9);
            id = (mode < 7 && span > 0) ? dir_ids[$urandom_range(0, span - 1)]
                                        : ID_W'($urandom);
            rtype = id[ID_W-1:TYPE_SHIFT] & TYPE_W'($urandom);
            mask = ID_W'(rtype) << TYPE_SHIFT;
            num = (id & ~mask) | (id & mask & ID_W'($urandom));
            if (mode == 9) begin
               rtype = TYPE_W'($urandom);
               num = ID_W'($urandom);
            end
            want = VOL_W'($urandom);
            if ($urandom_range(0, 1) && span > 0)
               split_word(dir_words[$urandom_range(0, span - 1)], off, want);
            send_query(rtype, num, want);
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   // Result side: stall in runs of random length
   always @(posedge clock) begin
      if (rx_run_left == 0) begin
         if (rx_stalling || no_idle) begin
            rsp_ch.ready <= 1'b1;
            rx_stalling = 1'b0;
            rx_run_left = $urandom_range(1, 20);
         end else begin
            rsp_ch.ready <= 1'b0;
            rx_stalling = 1'b1;
            rx_run_left = $urandom_range(1, 12);
         end
      end else begin
         rx_run_left--;
      end
   end

   always @(posedge clock) begin
      result_type want_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result item: found %0d offset %h vol_num %0d",
                   rsp_ch.found, rsp_ch.offset, rsp_ch.vol_num);
            error_count++;
         end else begin
            want_res = pending_lookups.pop_front();
            if (rsp_ch.found !== want_res.found) begin
               $error("found: expected %0d, got %0d", want_res.found, rsp_ch.found);
               error_count++;
            end
            if (rsp_ch.offset !== want_res.offset) begin
               $error("offset: expected %h, got %h", want_res.offset, rsp_ch.offset);
               error_count++;
            end
            if (rsp_ch.vol_num !== want_res.vol_num) begin
               $error("vol_num: expected %0d, got %0d", want_res.vol_num, rsp_ch.vol_num);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("** resource_directory_lookup: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_LOAD;
      req_ch.first_entry = 1'b0;
      req_ch.entry_id = '0;
      req_ch.entry_word = '0;
      req_ch.res_type = '0;
      req_ch.res_num = '0;
      req_ch.want_vol = '0;
      rsp_ch.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_directory();
      test_narrow_layout();
      test_wide_layout();
      test_random_sessions();

      req_ch.valid <= 1'b0;
      while (pending_lookups.size() != 0)
         @(posedge clock);
      // hold a while to catch stray result items
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("** resource_directory_lookup: PASSED **");
      else
         $display("** resource_directory_lookup: FAILED **");
      $finish;
   end

endmodule
